/* hw/rtl/cpu8_register_alu_execute_unit_defines.svh */
// assertion macros used by the checker file
`ifndef CPU8_REGISTER_ALU_EXECUTE_UNIT_DEFINES_SVH
`define CPU8_REGISTER_ALU_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CPU8_ASSERT_NOW(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("cpu8 execute unit check failed");

// next-cycle implication, disabled while reset is low
`define CPU8_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("cpu8 execute unit check failed");

`endif

/* hw/rtl/cpu8alu_pkg.sv */
// shared types and constants of the 8-bit register alu execute unit
package cpu8alu_pkg;

    localparam int KIND_W    = 5;
    localparam int BYTE_W    = 8;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 56;

    typedef enum logic [KIND_W-1:0] {
        OP_AND = 5'd0,
        OP_LDA = 5'd1,
        OP_LDX = 5'd2,
        OP_LDY = 5'd3,
        OP_ADC = 5'd4,
        OP_SBC = 5'd5,
        OP_CLC = 5'd6,
        OP_SEC = 5'd7,
        OP_INC = 5'd8,
        OP_INX = 5'd9,
        OP_INY = 5'd10,
        OP_DEC = 5'd11,
        OP_DEX = 5'd12,
        OP_DEY = 5'd13,
        OP_STX = 5'd14,
        OP_STY = 5'd15,
        OP_STA = 5'd16,
        OP_TAX = 5'd17,
        OP_TXA = 5'd18,
        OP_TAY = 5'd19,
        OP_TYA = 5'd20,
        OP_TSX = 5'd21,
        OP_TXS = 5'd22,
        OP_NOP = 5'd23
    } op_kind_t;

    // status bit positions
    localparam int FLAG_C_BIT = 0;
    localparam int FLAG_Z_BIT = 1;
    localparam int FLAG_V_BIT = 6;
    localparam int FLAG_N_BIT = 7;

    localparam logic [BYTE_W-1:0] SP_RESET     = 8'hFF;
    localparam logic [BYTE_W-1:0] STATUS_RESET = 8'h24;

    // fixed status bits 5..2 as placed in the result transfer
    localparam int                FIXED_FLAGS_LSB = 43;
    localparam logic [3:0]        FIXED_FLAGS     = 4'b1001;

endpackage

/* hw/rtl/cpu8_register_alu_execute_unit.sv */
// 8-bit register file and alu execute unit, one operation per transfer
//
// channel | dir | tdata fields (low bit up)
// s_*     | in  | kind[4:0], operand_value[12:5], zero pad [15:13]
// m_*     | out | mem_write[0], write_data[8:1], acc_out[16:9], x_out[24:17],
//         |     | y_out[32:25], sp_out[40:33], flags_out[48:41], zero pad [55:49]
//
// one operation per cycle sustained while m_tready holds high; an input register
// then a result register, with the 8-bit add/logic step between them
// the register file updates when an operation moves into the result register
// async reset: A/X/Y = 0, SP = 0xff, status = 0x24, both stages empty
// a stalled output holds its result; the input stage still takes one more item
module cpu8_register_alu_execute_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cpu8alu_pkg::S_TDATA_W-1:0]   s_tdata,   // kind, operand_value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cpu8alu_pkg::M_TDATA_W-1:0]   m_tdata    // mem_write, write_data,
                                                           // acc, x, y, sp, flags
);
    import cpu8alu_pkg::*;

    logic                in_valid_reg;
    logic [KIND_W-1:0]   in_kind_reg;
    logic [BYTE_W-1:0]   in_operand_reg;

    logic [BYTE_W-1:0]   acc_reg, acc_next;
    logic [BYTE_W-1:0]   x_reg, x_next;
    logic [BYTE_W-1:0]   y_reg, y_next;
    logic [BYTE_W-1:0]   sp_reg, sp_next;
    logic [BYTE_W-1:0]   flags_reg, flags_next;

    logic                out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic                advance;
    logic                s_xfer;
    logic                wr;
    logic [BYTE_W-1:0]   wdata;
    logic                nz_en;
    logic [BYTE_W-1:0]   nz_val;
    logic [BYTE_W-1:0]   addend;
    logic [BYTE_W:0]     sum;
    logic                overflow;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // sbc runs through the same adder with the operand inverted
    assign addend   = (in_kind_reg == OP_SBC) ? ~in_operand_reg : in_operand_reg;
    assign sum      = {1'b0, acc_reg} + {1'b0, addend}
                      + {{BYTE_W{1'b0}}, flags_reg[FLAG_C_BIT]};
    assign overflow = ~(acc_reg[BYTE_W-1] ^ addend[BYTE_W-1])
                      & (acc_reg[BYTE_W-1] ^ sum[BYTE_W-1]);

    always_comb
    begin
        acc_next   = acc_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        sp_next    = sp_reg;
        flags_next = flags_reg;
        wr         = 1'b0;
        wdata      = '0;
        nz_en      = 1'b0;
        nz_val     = '0;
        unique case (in_kind_reg)
            OP_AND:
            begin
                acc_next = acc_reg & in_operand_reg;
                nz_en = 1'b1; nz_val = acc_next;
            end
            OP_LDA:
            begin
                acc_next = in_operand_reg;
                nz_en = 1'b1; nz_val = acc_next;
            end
            OP_LDX:
            begin
                x_next = in_operand_reg;
                nz_en = 1'b1; nz_val = x_next;
            end
            OP_LDY:
            begin
                y_next = in_operand_reg;
                nz_en = 1'b1; nz_val = y_next;
            end
            OP_ADC, OP_SBC:
            begin
                acc_next = sum[BYTE_W-1:0];
                flags_next[FLAG_C_BIT] = sum[BYTE_W];
                flags_next[FLAG_V_BIT] = overflow;
                nz_en = 1'b1; nz_val = acc_next;
            end
            OP_CLC: flags_next[FLAG_C_BIT] = 1'b0;
            OP_SEC: flags_next[FLAG_C_BIT] = 1'b1;
            OP_INC:
            begin
                wr = 1'b1; wdata = in_operand_reg + 8'd1;
                nz_en = 1'b1; nz_val = wdata;
            end
            OP_INX:
            begin
                x_next = x_reg + 8'd1;
                nz_en = 1'b1; nz_val = x_next;
            end
            OP_INY:
            begin
                y_next = y_reg + 8'd1;
                nz_en = 1'b1; nz_val = y_next;
            end
            OP_DEC:
            begin
                wr = 1'b1; wdata = in_operand_reg - 8'd1;
                nz_en = 1'b1; nz_val = wdata;
            end
            OP_DEX:
            begin
                x_next = x_reg - 8'd1;
                nz_en = 1'b1; nz_val = x_next;
            end
            OP_DEY:
            begin
                y_next = y_reg - 8'd1;
                nz_en = 1'b1; nz_val = y_next;
            end
            OP_STX:
            begin
                wr = 1'b1; wdata = x_reg;
            end
            OP_STY:
            begin
                wr = 1'b1; wdata = y_reg;
            end
            OP_STA:
            begin
                wr = 1'b1; wdata = acc_reg;
            end
            OP_TAX:
            begin
                x_next = acc_reg;
                nz_en = 1'b1; nz_val = x_next;
            end
            OP_TXA:
            begin
                acc_next = x_reg;
                nz_en = 1'b1; nz_val = acc_next;
            end
            OP_TAY:
            begin
                y_next = acc_reg;
                nz_en = 1'b1; nz_val = y_next;
            end
            OP_TYA:
            begin
                acc_next = y_reg;
                nz_en = 1'b1; nz_val = acc_next;
            end
            OP_TSX:
            begin
                x_next = sp_reg;
                nz_en = 1'b1; nz_val = x_next;
            end
            OP_TXS: sp_next = x_reg;
            OP_NOP: ;
            // unassigned codes act as nop
            default: ;
        endcase
        if (nz_en)
        begin
            flags_next[FLAG_N_BIT] = nz_val[BYTE_W-1];
            flags_next[FLAG_Z_BIT] = (nz_val == '0);
        end
        out_data_next = {7'b0, flags_next, sp_next, y_next, x_next, acc_next, wdata, wr};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            sp_reg        <= SP_RESET;
            flags_reg     <= STATUS_RESET;
        end
        else
        begin
            if (s_xfer)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                acc_reg   <= acc_next;
                x_reg     <= x_next;
                y_reg     <= y_next;
                sp_reg    <= sp_next;
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_kind_reg    <= s_tdata[KIND_W-1:0];
            in_operand_reg <= s_tdata[KIND_W +: BYTE_W];
        end
        if (advance)
            out_data_reg <= out_data_next;
    end

endmodule

/* hw/rtl/cpu8alu_checker.sv */
// port-level checks of the execute unit and their bind
`include "cpu8_register_alu_execute_unit_defines.svh"

module cpu8alu_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [cpu8alu_pkg::M_TDATA_W-1:0]   m_tdata
);
    import cpu8alu_pkg::*;

    logic in_xfer_seen;

    assign in_xfer_seen = s_tvalid && s_tready;

    // a result without a store carries a zero store byte
    `CPU8_ASSERT_NOW(a_wdata_zero, clk, rst_n, m_tvalid && !m_tdata[0], m_tdata[BYTE_W:1] == '0)
    // status bits 5..2 never leave their reset pattern
    `CPU8_ASSERT_NOW(a_fixed_flags, clk, rst_n, m_tvalid, m_tdata[FIXED_FLAGS_LSB +: 4] == FIXED_FLAGS)
    // a stalled result stays put
    `CPU8_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // with the input stage full, the input is ready only when the result can move on
    `CPU8_ASSERT_NEXT(a_in_full, clk, rst_n, in_xfer_seen, s_tready == (!m_tvalid || m_tready))

endmodule

bind cpu8_register_alu_execute_unit cpu8alu_checker u_cpu8alu_checker (.*);

/* tb/tb_top.sv */
// self-checking testbench for the 8-bit register alu execute unit
`timescale 1ns / 100ps

module tb_top;
    import cpu8alu_pkg::*;

    localparam logic [KIND_W-1:0] KIND_LAST_CODE = 5'd31;
    localparam int                STALL_LIMIT    = 1000;
    localparam int                SETTLE_CYCLES  = 8;
    localparam int                RANDOM_OPS     = 1130;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] operand;
        bit                drain;
    } alu_op_t;

    // same layout as m_tdata, msb first
    typedef struct packed {
        logic [6:0]        pad;
        logic [BYTE_W-1:0] flags;
        logic [BYTE_W-1:0] sp;
        logic [BYTE_W-1:0] y;
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] wdata;
        logic              wr;
    } exec_result_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    alu_op_t      op_queue[$];
    exec_result_t pending_results[$];

    // register file and status as the block should hold them
    logic [BYTE_W-1:0] reg_a  = '0;
    logic [BYTE_W-1:0] reg_x  = '0;
    logic [BYTE_W-1:0] reg_y  = '0;
    logic [BYTE_W-1:0] reg_sp = SP_RESET;
    logic [BYTE_W-1:0] reg_p  = STATUS_RESET;

    bit in_taken   = 1'b0;
    bit out_taken  = 1'b0;
    bit calm       = 1'b0;
    int gap_left   = 0;
    int stall_left = 0;
    int idle_cycles  = 0;
    int ops_total    = 0;
    int ops_accepted = 0;
    int err_cnt      = 0;

    cpu8_register_alu_execute_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int draw_idle();
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic void set_nz(logic [BYTE_W-1:0] v);
        reg_p[FLAG_N_BIT] = v[7];
        reg_p[FLAG_Z_BIT] = (v == '0);
    endfunction

    function automatic exec_result_t execute_op(logic [KIND_W-1:0] kind,
                                                logic [BYTE_W-1:0] opnd);
        exec_result_t      r;
        logic [8:0]        sum;
        logic [BYTE_W-1:0] res;
        logic              cin;
        r   = '0;
        cin = reg_p[FLAG_C_BIT];
        case (kind)
            OP_AND:
            begin
                reg_a = reg_a & opnd;
                set_nz(reg_a);
            end
            OP_LDA:
            begin
                reg_a = opnd;
                set_nz(reg_a);
            end
            OP_LDX:
            begin
                reg_x = opnd;
                set_nz(reg_x);
            end
            OP_LDY:
            begin
                reg_y = opnd;
                set_nz(reg_y);
            end
            OP_ADC:
            begin
                sum = {1'b0, reg_a} + {1'b0, opnd} + {8'd0, cin};
                res = sum[7:0];
                reg_p[FLAG_V_BIT] = ~(reg_a[7] ^ opnd[7]) & (reg_a[7] ^ res[7]);
                reg_p[FLAG_C_BIT] = sum[8];
                reg_a = res;
                set_nz(res);
            end
            OP_SBC:
            begin
                // bit 8 of the 9-bit difference is the borrow; carry is its inverse
                sum = {1'b0, reg_a} - {1'b0, opnd} - {8'd0, ~cin};
                res = sum[7:0];
                reg_p[FLAG_V_BIT] = (reg_a[7] ^ res[7]) & (reg_a[7] ^ opnd[7]);
                reg_p[FLAG_C_BIT] = ~sum[8];
                reg_a = res;
                set_nz(res);
            end
            OP_CLC: reg_p[FLAG_C_BIT] = 1'b0;
            OP_SEC: reg_p[FLAG_C_BIT] = 1'b1;
            OP_INC:
            begin
                r.wr    = 1'b1;
                r.wdata = opnd + 8'd1;
                set_nz(r.wdata);
            end
            OP_INX:
            begin
                reg_x = reg_x + 8'd1;
                set_nz(reg_x);
            end
            OP_INY:
            begin
                reg_y = reg_y + 8'd1;
                set_nz(reg_y);
            end
            OP_DEC:
            begin
                r.wr    = 1'b1;
                r.wdata = opnd - 8'd1;
                set_nz(r.wdata);
            end
            OP_DEX:
            begin
                reg_x = reg_x - 8'd1;
                set_nz(reg_x);
            end
            OP_DEY:
            begin
                reg_y = reg_y - 8'd1;
                set_nz(reg_y);
            end
            OP_STX:
            begin
                r.wr    = 1'b1;
                r.wdata = reg_x;
            end
            OP_STY:
            begin
                r.wr    = 1'b1;
                r.wdata = reg_y;
            end
            OP_STA:
            begin
                r.wr    = 1'b1;
                r.wdata = reg_a;
            end
            OP_TAX:
            begin
                reg_x = reg_a;
                set_nz(reg_x);
            end
            OP_TXA:
            begin
                reg_a = reg_x;
                set_nz(reg_a);
            end
            OP_TAY:
            begin
                reg_y = reg_a;
                set_nz(reg_y);
            end
            OP_TYA:
            begin
                reg_a = reg_y;
                set_nz(reg_a);
            end
            OP_TSX:
            begin
                reg_x = reg_sp;
                set_nz(reg_x);
            end
            OP_TXS: reg_sp = reg_x;
            default: ;
        endcase
        r.acc   = reg_a;
        r.x     = reg_x;
        r.y     = reg_y;
        r.sp    = reg_sp;
        r.flags = reg_p;
        return r;
    endfunction

    task automatic check_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %02h, actual %02h", name, want, got);
            err_cnt++;
        end
    endtask

    task automatic add_op(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] operand,
                          bit drain = 1'b0);
        alu_op_t op;
        op.kind    = kind;
        op.operand = operand;
        op.drain   = drain;
        op_queue.push_back(op);
    endtask

    // sender: one item per transfer, random gap after each one
    always @(negedge clk)
    begin
        alu_op_t op;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            gap_left <= 0;
        end
        else if (s_tvalid && !in_taken)
        begin
            // hold the item until it is taken
        end
        else if (gap_left != 0)
        begin
            s_tvalid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (op_queue.size() != 0 && !(op_queue[0].drain && pending_results.size() != 0))
        begin
            op = op_queue.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= {3'b000, op.operand, op.kind};
            gap_left <= draw_idle();
            if ($urandom_range(0, 39) == 0)
                calm <= !calm;
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver: random stall after each result
    always @(negedge clk)
    begin
        int n;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (out_taken)
        begin
            n = draw_idle();
            m_tready   <= (n == 0);
            stall_left <= (n == 0) ? 0 : n - 1;
        end
        else if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // monitor: check results, predict on each accepted operation, watchdog
    always @(posedge clk)
    begin
        exec_result_t got;
        exec_result_t want;
        if (!rst_n)
        begin
            in_taken    <= 1'b0;
            out_taken   <= 1'b0;
            idle_cycles <= 0;
            reg_a  = '0;
            reg_x  = '0;
            reg_y  = '0;
            reg_sp = SP_RESET;
            reg_p  = STATUS_RESET;
            pending_results.delete();
        end
        else
        begin
            in_taken  <= s_tvalid && s_tready;
            out_taken <= m_tvalid && m_tready;
            if (m_tvalid && m_tready)
            begin
                got = exec_result_t'(m_tdata);
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with no operation outstanding: %014h", m_tdata);
                    err_cnt++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("mem_write", {7'd0, want.wr}, {7'd0, got.wr});
                    check_field("write_data", want.wdata, got.wdata);
                    check_field("acc_out", want.acc, got.acc);
                    check_field("x_out", want.x, got.x);
                    check_field("y_out", want.y, got.y);
                    check_field("sp_out", want.sp, got.sp);
                    check_field("flags_out", want.flags, got.flags);
                end
            end
            if (s_tvalid && s_tready)
            begin
                pending_results.push_back(execute_op(s_tdata[4:0], s_tdata[12:5]));
                ops_accepted++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles < STALL_LIMIT)
                idle_cycles <= idle_cycles + 1;
            else
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] operand;
        // directed: corner operands, every operation, carry and overflow edges
        add_op(OP_LDA, 8'h80);
        add_op(OP_LDX, 8'hFF);
        add_op(OP_LDY, 8'h00);
        add_op(OP_AND, 8'h7F);
        add_op(OP_LDA, 8'h7F);
        add_op(OP_ADC, 8'h01);
        add_op(OP_ADC, 8'hFF);
        add_op(OP_SBC, 8'h80);
        add_op(OP_SEC, 8'hFF);
        add_op(OP_CLC, 8'hFF);
        add_op(OP_SBC, 8'h00);
        add_op(OP_INC, 8'hFF);
        add_op(OP_DEC, 8'h00);
        add_op(OP_INX, 8'hA5);
        add_op(OP_INY, 8'h5A);
        add_op(OP_DEX, 8'h00);
        add_op(OP_DEY, 8'hFF);
        add_op(OP_STX, 8'h00);
        add_op(OP_STY, 8'hFF);
        add_op(OP_STA, 8'h55);
        add_op(OP_TAX, 8'h00);
        add_op(OP_TXA, 8'hFF);
        add_op(OP_TAY, 8'h00);
        add_op(OP_TYA, 8'hFF);
        add_op(OP_TXS, 8'h00);
        add_op(OP_TSX, 8'hFF);
        add_op(OP_NOP, 8'hFF);
        add_op(KIND_LAST_CODE, 8'hFF);
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                kind = KIND_W'($urandom_range(OP_NOP + 1, KIND_LAST_CODE));
            else
                kind = KIND_W'($urandom_range(OP_AND, OP_NOP));
            case ($urandom_range(0, 11))
                0:       operand = 8'h00;
                1:       operand = 8'hFF;
                2:       operand = 8'h7F;
                3:       operand = 8'h80;
                default: operand = BYTE_W'($urandom_range(0, 255));
            endcase
            // now and then let the pipeline run dry before the next operation
            add_op(kind, operand, (i % 300) == 150);
        end
        ops_total = op_queue.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (ops_accepted != ops_total || pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/cpu8alu_pkg.sv
hw/rtl/cpu8_register_alu_execute_unit.sv
hw/rtl/cpu8alu_checker.sv
tb/tb_top.sv
